>>> sv/lolbi_pkg.sv
// Shared widths, reset values and run arithmetic for the longest-line-of-ones block.
package lolbi_pkg;

   localparam int RUN_W           = 11;
   localparam int CFG_W           = 11;
   localparam int DEF_MAX_COLUMNS = 1024;

   typedef logic [RUN_W-1:0] run_type;
   typedef logic [CFG_W-1:0] width_cfg_type;

   localparam run_type       RUN_MAX       = {RUN_W{1'b1}};
   localparam width_cfg_type ROW_WIDTH_RST = CFG_W'(1024);

   function automatic run_type run_extend(input run_type prior);
      run_type res;
      res = (prior == RUN_MAX) ? RUN_MAX : prior + RUN_W'(1);
      return res;
   endfunction

   function automatic run_type run_max(input run_type a, input run_type b);
      run_type res;
      res = (a > b) ? a : b;
      return res;
   endfunction

endpackage

>>> sv/lolbi_ifs.sv
// Channel interfaces: pixel requests, run-length responses and the row width write port.
interface lolbi_req_if import lolbi_pkg::*; ();
   logic valid;
   logic ready;
   logic pixel;
   logic first_of_frame;
   logic last_of_frame;

   modport source (output valid, pixel, first_of_frame, last_of_frame, input ready);
   modport sink   (input valid, pixel, first_of_frame, last_of_frame, output ready);
endinterface

interface lolbi_rsp_if import lolbi_pkg::*; ();
   logic    valid;
   logic    ready;
   run_type longest;
   logic    frame_done;

   modport source (output valid, longest, frame_done, input ready);
   modport sink   (input valid, longest, frame_done, output ready);
endinterface

interface lolbi_csr_if import lolbi_pkg::*; ();
   logic          valid;
   logic          ready;
   width_cfg_type row_width;

   modport source (output valid, row_width, input ready);
   modport sink   (input valid, row_width, output ready);
endinterface

>>> sv/longest_line_of_ones_binary_image_top.sv
// Top level: streaming longest line of ones over a raster-order binary image.
//
//  channel  dir  payload                                  transaction
//  req_ch   in   pixel, first_of_frame, last_of_frame     valid & ready
//  rsp_ch   out  longest[10:0], frame_done                valid & ready
//  csr_ch   in   row_width[10:0]                          valid & ready, always ready
//
//  One pixel per cycle while the response side does not stall. The accept edge issues
//  the line buffer reads; the compute stage forms runs and loads the response register.
//  Line buffer writes of the previous pixel are bypassed into same-cycle reads.
//  Reset clears control state only; line buffers need no clearing pass.
//  A stalled response holds the compute stage, which then holds the request side.
module longest_line_of_ones_binary_image_top
   import lolbi_pkg::*;
#(
   parameter int MAX_COLUMNS = DEF_MAX_COLUMNS
) (
   input  logic        clock,
   input  logic        reset,
   lolbi_req_if.sink   req_ch,
   lolbi_rsp_if.source rsp_ch,
   lolbi_csr_if.sink   csr_ch
);

   localparam int COL_W = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
   localparam int CMP_W = (COL_W + 1 > CFG_W) ? COL_W + 1 : CFG_W;

   typedef struct packed {
      logic pixel;
      logic first_row;
      logic start;
      logic row_end;
      logic last;
   } stage_ctl_type;

   width_cfg_type row_width_ff;

   logic             restart_ff, restart_in;
   logic             first_row_ff, first_row_in;
   logic [COL_W-1:0] col_ff, col_in;

   logic             valid_b_ff, valid_b_in;
   stage_ctl_type    ctl_b_ff, ctl_b_in;
   logic [COL_W-1:0] col_b_ff;

   run_type rd_v_ff, rd_d_ff, rd_a_ff;
   run_type hrun_ff, held_ff, best_ff;

   logic    rsp_valid_ff, rsp_valid_in;
   run_type rsp_longest_ff;
   logic    rsp_done_ff;

   run_type vert_mem [MAX_COLUMNS];
   run_type diag_mem [MAX_COLUMNS];
   run_type anti_mem [MAX_COLUMNS];

   logic             acc, b_adv, start;
   logic [COL_W-1:0] col_eff, anti_addr;
   logic [COL_W:0]   col_plus;
   logic [CMP_W-1:0] w_eff;
   logic             frow_eff, row_end;
   logic             fwd_vd, fwd_a;

   run_type h_run, v_run, d_run, a_run;
   run_type up, upleft, upright, best_base, best_in;

   // configuration
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_width_ff <= ROW_WIDTH_RST;
      end else if (csr_ch.valid) begin
         row_width_ff <= csr_ch.row_width;
      end
   end

   // handshakes
   assign b_adv        = valid_b_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !valid_b_ff || b_adv;
   assign acc          = req_ch.valid && req_ch.ready;

   // column tracking at the accept edge
   always_comb begin
      if (row_width_ff == '0) begin
         w_eff = CMP_W'(1);
      end else if (CMP_W'(row_width_ff) > CMP_W'(MAX_COLUMNS)) begin
         w_eff = CMP_W'(MAX_COLUMNS);
      end else begin
         w_eff = CMP_W'(row_width_ff);
      end
      start     = req_ch.first_of_frame || restart_ff;
      col_eff   = start ? '0 : col_ff;
      frow_eff  = start ? 1'b1 : first_row_ff;
      col_plus  = {1'b0, col_eff} + (COL_W+1)'(1);
      row_end   = CMP_W'(col_plus) >= w_eff;
      anti_addr = COL_W'(col_plus);
      fwd_vd    = valid_b_ff && (col_b_ff == col_eff);
      fwd_a     = valid_b_ff && (col_b_ff == anti_addr);

      restart_in   = restart_ff;
      first_row_in = first_row_ff;
      col_in       = col_ff;
      if (acc) begin
         restart_in = req_ch.last_of_frame;
         if (row_end) begin
            col_in       = '0;
            first_row_in = 1'b0;
         end else begin
            col_in       = anti_addr;
            first_row_in = frow_eff;
         end
      end

      ctl_b_in.pixel     = req_ch.pixel;
      ctl_b_in.first_row = frow_eff;
      ctl_b_in.start     = start;
      ctl_b_in.row_end   = row_end;
      ctl_b_in.last      = req_ch.last_of_frame;

      valid_b_in = acc ? 1'b1 : (b_adv ? 1'b0 : valid_b_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         restart_ff   <= 1'b1;
         first_row_ff <= 1'b1;
         col_ff       <= '0;
         valid_b_ff   <= 1'b0;
      end else begin
         restart_ff   <= restart_in;
         first_row_ff <= first_row_in;
         col_ff       <= col_in;
         valid_b_ff   <= valid_b_in;
      end
   end

   always_ff @(posedge clock) begin
      if (acc) begin
         ctl_b_ff <= ctl_b_in;
         col_b_ff <= col_eff;
      end
   end

   // line buffers, read at accept with bypass of the write in flight
   always_ff @(posedge clock) begin
      if (b_adv) begin
         vert_mem[col_b_ff] <= v_run;
         diag_mem[col_b_ff] <= d_run;
         anti_mem[col_b_ff] <= a_run;
      end
   end

   always_ff @(posedge clock) begin
      if (acc) begin
         rd_v_ff <= fwd_vd ? v_run : vert_mem[col_eff];
         rd_d_ff <= fwd_vd ? d_run : diag_mem[col_eff];
         rd_a_ff <= fwd_a  ? a_run : anti_mem[anti_addr];
      end
   end

   // run computation
   always_comb begin
      up        = ctl_b_ff.first_row ? '0 : rd_v_ff;
      upleft    = (ctl_b_ff.first_row || col_b_ff == '0) ? '0 : held_ff;
      upright   = (ctl_b_ff.first_row || ctl_b_ff.row_end) ? '0 : rd_a_ff;
      h_run     = '0;
      v_run     = '0;
      d_run     = '0;
      a_run     = '0;
      if (ctl_b_ff.pixel) begin
         h_run = (col_b_ff == '0) ? RUN_W'(1) : run_extend(hrun_ff);
         v_run = run_extend(up);
         d_run = run_extend(upleft);
         a_run = run_extend(upright);
      end
      best_base = ctl_b_ff.start ? '0 : best_ff;
      best_in   = run_max(best_base, run_max(run_max(h_run, v_run), run_max(d_run, a_run)));
      rsp_valid_in = b_adv ? 1'b1 : (rsp_ch.ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (b_adv) begin
         hrun_ff        <= h_run;
         held_ff        <= rd_d_ff;
         best_ff        <= best_in;
         rsp_longest_ff <= best_in;
         rsp_done_ff    <= ctl_b_ff.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.longest    = rsp_longest_ff;
   assign rsp_ch.frame_done = rsp_done_ff;

   // checks
   a_start_col0: assert property (@(posedge clock) disable iff (reset)
      acc && start |=> (col_b_ff == '0) && ctl_b_ff.first_row)
      else $error("frame start did not land on column 0 of the first row");

   a_hold_blocks_req: assert property (@(posedge clock) disable iff (reset)
      valid_b_ff && !b_adv |-> !acc)
      else $error("transaction accepted while compute stage is held");

   a_best_monotone: assert property (@(posedge clock) disable iff (reset)
      b_adv && !ctl_b_ff.start |-> best_in >= best_ff)
      else $error("longest decreased within a frame");

   a_one_nonzero: assert property (@(posedge clock) disable iff (reset)
      b_adv && ctl_b_ff.pixel |-> best_in != '0)
      else $error("set pixel produced a zero result");

endmodule

>>> tb/lolbi_scoreboard_pkg.sv
`timescale 1ns / 1ps
// Scoreboard for the longest-line-of-ones block: pixel-stream predictor and response checks.
package lolbi_scoreboard_pkg;
   import lolbi_pkg::*;

   localparam int SHOWN_MISMATCHES = 25;

   typedef struct packed {
      run_type longest;
      logic    frame_done;
   } line_answer_type;

   class longest_line_scoreboard;
      width_cfg_type   row_width;
      int unsigned     column_pos;
      bit              top_row;
      run_type         horiz_run;
      run_type         vert_runs[DEF_MAX_COLUMNS];
      run_type         diag_runs[DEF_MAX_COLUMNS];
      run_type         anti_runs[DEF_MAX_COLUMNS];
      run_type         diag_left;
      run_type         best_len;
      run_type         peak_len;
      line_answer_type expected_answers[$];
      int unsigned     mismatches;
      int unsigned     pixels_checked;
      int unsigned     frames_closed;

      function new();
         row_width      = ROW_WIDTH_RST;
         mismatches     = 0;
         pixels_checked = 0;
         frames_closed  = 0;
         peak_len       = '0;
         foreach (vert_runs[i]) begin
            vert_runs[i] = '0;
            diag_runs[i] = '0;
            anti_runs[i] = '0;
         end
         restart_frame();
      endfunction

      function void restart_frame();
         column_pos = 0;
         top_row    = 1'b1;
         horiz_run  = '0;
         diag_left  = '0;
         best_len   = '0;
      endfunction

      function void set_row_width(width_cfg_type value);
         row_width = value;
      endfunction

      // saturating increment of a run length
      function run_type lengthen(run_type r);
         logic [RUN_W:0] total;
         total = {1'b0, r} + 1'b1;
         return total[RUN_W] ? RUN_MAX : total[RUN_W-1:0];
      endfunction

      function run_type widest(run_type x, run_type y);
         return (x > y) ? x : y;
      endfunction

      function void note_pixel(logic pix, logic is_first, logic is_last);
         int unsigned     w;
         int unsigned     c;
         bit              row_end;
         run_type         h, v, d, a;
         run_type         up, up_left, up_right;
         line_answer_type ans;
         if (is_first) restart_frame();
         w = 32'(row_width);
         if (w < 1) w = 1;
         if (w > DEF_MAX_COLUMNS) w = DEF_MAX_COLUMNS;
         c = (column_pos >= DEF_MAX_COLUMNS) ? DEF_MAX_COLUMNS - 1 : column_pos;
         row_end = (c + 1 >= w);

         up       = top_row ? '0 : vert_runs[c];
         up_left  = (top_row || c == 0) ? '0 : diag_left;
         up_right = (top_row || row_end) ? '0 : anti_runs[c + 1];
         if (!pix) h = '0;
         else if (c == 0) h = RUN_W'(1);
         else h = lengthen(horiz_run);
         v = pix ? lengthen(up) : '0;
         d = pix ? lengthen(up_left) : '0;
         a = pix ? lengthen(up_right) : '0;

         // keep the previous row's diagonal of this column for the next pixel
         diag_left    = diag_runs[c];
         vert_runs[c] = v;
         diag_runs[c] = d;
         anti_runs[c] = a;
         horiz_run    = h;
         best_len     = widest(best_len, widest(widest(h, v), widest(d, a)));
         if (best_len > peak_len) peak_len = best_len;

         ans.longest    = best_len;
         ans.frame_done = is_last;
         expected_answers.push_back(ans);

         if (is_last) begin
            frames_closed++;
            restart_frame();
         end else if (row_end) begin
            column_pos = 0;
            top_row    = 1'b0;
            horiz_run  = '0;
         end else begin
            column_pos = c + 1;
         end
      endfunction

      task report_mismatch(string what);
         mismatches++;
         if (mismatches <= SHOWN_MISMATCHES)
            $display("[%0t] mismatch: %s", $time, what);
      endtask

      task check_result(run_type longest, logic frame_done);
         line_answer_type want;
         if (expected_answers.size() == 0) begin
            report_mismatch($sformatf("unexpected transaction, longest=%0d frame_done=%0b",
                                      longest, frame_done));
         end else begin
            want = expected_answers.pop_front();
            pixels_checked++;
            if (longest !== want.longest)
               report_mismatch($sformatf("pixel %0d longest=%0d, expected %0d",
                                         pixels_checked, longest, want.longest));
            if (frame_done !== want.frame_done)
               report_mismatch($sformatf("pixel %0d frame_done=%0b, expected %0b",
                                         pixels_checked, frame_done, want.frame_done));
         end
      endtask
   endclass

endpackage

>>> tb/tb_longest_line_of_ones_binary_image_top.sv
`timescale 1ns / 1ps
// Testbench top: streams binary image frames and row width writes, checks every response.
module tb_longest_line_of_ones_binary_image_top;
   import lolbi_pkg::*;
   import lolbi_scoreboard_pkg::*;

   localparam int STALL_LIMIT  = 2000;
   localparam int LONG_HOLD    = 64;
   localparam int PHASE_ITEMS  = 20;
   localparam int PHASES       = 4;
   localparam int TAIL_CYCLES  = 8;
   localparam int SAT_PIXELS   = 40;
   localparam int WIDE_PIXELS  = 640;

   logic clock;
   logic reset;

   lolbi_req_if req_ch ();
   lolbi_rsp_if rsp_ch ();
   lolbi_csr_if csr_ch ();

   longest_line_scoreboard line_checker;
   int unsigned sender_idle_pct;
   int unsigned receiver_idle_pct;
   bit          long_hold_request;
   int unsigned quiet_cycles;
   int unsigned width_writes;

   longest_line_of_ones_binary_image_top dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int unsigned effective_width(width_cfg_type cfg);
      if (cfg == 0) return 1;
      if (cfg > DEF_MAX_COLUMNS) return DEF_MAX_COLUMNS;
      return 32'(cfg);
   endfunction

   task automatic send_pixel(input logic pix, input logic is_first, input logic is_last);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid          <= 1'b1;
      req_ch.pixel          <= pix;
      req_ch.first_of_frame <= is_first;
      req_ch.last_of_frame  <= is_last;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      line_checker.note_pixel(pix, is_first, is_last);
   endtask

   // stop offering and wait until every response is back
   task automatic settle();
      req_ch.valid <= 1'b0;
      while (line_checker.expected_answers.size() != 0) @(posedge clock);
   endtask

   task automatic write_row_width(input width_cfg_type value);
      settle();
      csr_ch.valid     <= 1'b1;
      csr_ch.row_width <= value;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      csr_ch.valid <= 1'b0;
      line_checker.set_row_width(value);
      width_writes++;
   endtask

   task automatic send_random_frames(input int unsigned eff_width, input int unsigned budget);
      int unsigned sent;
      int unsigned len;
      int unsigned density;
      logic        is_first;
      logic        is_last;
      sent = 0;
      while (sent < budget) begin
         len = $urandom_range(1, 6) * eff_width;
         if (len > budget - sent) len = budget - sent;
         if ($urandom_range(7) == 0) len = $urandom_range(1, len);
         case ($urandom_range(3))
            0:       density = 50;
            1:       density = 80;
            2:       density = 95;
            default: density = 100;
         endcase
         for (int unsigned i = 0; i < len; i++) begin
            is_first = (i == 0) ? ($urandom_range(3) != 0) : ($urandom_range(199) == 0);
            is_last  = (i == len - 1) && ($urandom_range(9) != 0);
            send_pixel($urandom_range(99) < density, is_first, is_last);
         end
         sent += len;
      end
      // close the frame so the next width may grow
      send_pixel(1'($urandom_range(1)), 1'b0, 1'b1);
   endtask

   task automatic run_directed();
      logic [8:0] anti_line;
      anti_line = 9'b001_010_100;
      // reset width still in force
      send_pixel(1'b1, 1'b1, 1'b0);
      send_pixel(1'b1, 1'b0, 1'b0);
      send_pixel(1'b0, 1'b0, 1'b1);

      write_row_width(11'd3);
      for (int i = 0; i < 9; i++)
         send_pixel(anti_line[i], i == 0, i == 8);
      // new frame without a start flag, then a restart inside the frame
      send_pixel(1'b1, 1'b0, 1'b0);
      send_pixel(1'b1, 1'b1, 1'b0);
      send_pixel(1'b1, 1'b0, 1'b1);

      // width shrinks mid-row, past the current column
      write_row_width(11'd4);
      for (int i = 0; i < 7; i++)
         send_pixel(1'b1, i == 0, 1'b0);
      write_row_width(11'd2);
      send_pixel(1'b1, 1'b0, 1'b0);
      send_pixel(1'b1, 1'b0, 1'b1);

      // single column: long vertical run
      write_row_width(11'd0);
      for (int i = 0; i < SAT_PIXELS; i++)
         send_pixel(1'b1, i == 0, i == SAT_PIXELS - 1);

      // widest rows, clamped from the largest setting
      write_row_width(11'd2047);
      for (int i = 0; i < WIDE_PIXELS; i++)
         send_pixel($urandom_range(9) != 0, i == 0, i == WIDE_PIXELS - 1);
   endtask

   initial begin
      width_cfg_type cfg;
      line_checker = new();
      width_writes = 0;
      long_hold_request = 1'b0;
      sender_idle_pct   = 35;
      receiver_idle_pct = 84;
      reset                 <= 1'b1;
      req_ch.valid          <= 1'b0;
      req_ch.pixel          <= 1'b0;
      req_ch.first_of_frame <= 1'b0;
      req_ch.last_of_frame  <= 1'b0;
      csr_ch.valid          <= 1'b0;
      csr_ch.row_width      <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      run_directed();

      for (int mode = 0; mode < 3; mode++) begin
         case (mode)
            0: begin
               sender_idle_pct   = 35;
               receiver_idle_pct = 84;
            end
            1: begin
               sender_idle_pct   = 84;
               receiver_idle_pct = 35;
            end
            default: begin
               sender_idle_pct   = 0;
               receiver_idle_pct = 0;
            end
         endcase
         for (int ph = 0; ph < PHASES; ph++) begin
            case ($urandom_range(9))
               0:       cfg = '0;
               1:       cfg = width_cfg_type'($urandom_range(13, 2047));
               default: cfg = width_cfg_type'($urandom_range(1, 12));
            endcase
            write_row_width(cfg);
            if (mode == 2 && ph == 0) long_hold_request = 1'b1;
            send_random_frames(effective_width(cfg), PHASE_ITEMS);
         end
      end

      settle();
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("covered %0d pixels in %0d closed frames over %0d row width settings",
               line_checker.pixels_checked, line_checker.frames_closed, width_writes);
      $display("longest line seen %0d, mismatches %0d",
               line_checker.peak_len, line_checker.mismatches);
      if (line_checker.mismatches == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

   initial begin
      int unsigned hold_left;
      hold_left = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready)
            line_checker.check_result(rsp_ch.longest, rsp_ch.frame_done);
         if (long_hold_request) begin
            long_hold_request = 1'b0;
            hold_left = LONG_HOLD;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= receiver_idle_pct);
         end
      end
   end

   initial begin
      quiet_cycles = 0;
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
             || (csr_ch.valid && csr_ch.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("no transaction for %0d cycles", STALL_LIMIT);
      $display("CHECK FAILED");
      $finish;
   end

endmodule

>>> files.f
sv/lolbi_pkg.sv
sv/lolbi_ifs.sv
sv/longest_line_of_ones_binary_image_top.sv
tb/lolbi_scoreboard_pkg.sv
tb/tb_longest_line_of_ones_binary_image_top.sv
